[rtl/core/feb_pkg.sv]
// Shared types and constants for the fire effect buffer update block.
// Depends on nothing; imported by feb_ram, fire_effect_buffer_update and its testbench.
package feb_pkg;

  localparam int DEF_WIDTH     = 56;
  localparam int DEF_HEIGHT    = 56;
  localparam int DEF_SEED_SPAN = 64;

  localparam int COL_W = 6;
  localparam int VAL_W = 8;
  localparam int IDX_W = 12;
  localparam int SUM_W = 10;

  typedef enum logic [1:0] {
    ACT_HOT  = 2'd0,
    ACT_COOL = 2'd1,
    ACT_STEP = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HOT_WR,
    ST_COOL_RD,
    ST_COOL_WR,
    ST_SUM_RD,
    ST_SUM_WB
  } state_t;

endpackage

[rtl/core/fire_effect_buffer_update.sv]
// Fire effect intensity store: seed writes from the start of row HEIGHT-1 and an in-place averaging sweep.
// A step result is registered onto m_tdata as its average is written back. No new item is taken
// until the last one is done (step: four reads, one write; hot: one write; cool: one read, one write;
// ignored: none), and a step also waits out any m_tready stall. Synchronous reset clears all
// WIDTH*(HEIGHT+1) entries, one a cycle, with s_tready low; the sweep restarts at the top cell.
// Depends on feb_pkg and feb_ram.
module fire_effect_buffer_update import feb_pkg::*; #(
  parameter int WIDTH     = DEF_WIDTH,
  parameter int HEIGHT    = DEF_HEIGHT,
  parameter int SEED_SPAN = DEF_SEED_SPAN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // seed_column[5:0], seed_value[13:6], source_column[19:14], zero pad [23:20]
  input  logic [23:0] s_tdata,
  // action[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // cell_index[11:0], intensity[19:12], zero pad [23:20]
  output logic [23:0] m_tdata,
  output logic        m_tlast
);

  localparam int STORE_SIZE = WIDTH * (HEIGHT + 1);
  localparam int AW         = $clog2(STORE_SIZE);
  localparam int BASE       = (HEIGHT - 1) * WIDTH;

  localparam logic [AW-1:0]      SWEEP_TOP = AW'(BASE - 1);
  localparam logic [AW-1:0]      LAST_IDX  = AW'(STORE_SIZE - 1);
  localparam logic [AW-1:0]      W_M1      = AW'(WIDTH - 1);
  localparam logic [AW-1:0]      W_0       = AW'(WIDTH);
  localparam logic [AW-1:0]      W_P1      = AW'(WIDTH + 1);
  localparam logic [AW-1:0]      ONE       = AW'(1);
  localparam logic [AW:0]        BASE_X    = (AW + 1)'(BASE);
  localparam logic [AW:0]        SIZE_X    = (AW + 1)'(STORE_SIZE);
  localparam logic [COL_W+2:0]   SPAN_X    = (COL_W + 3)'(SEED_SPAN);

  function automatic logic [COL_W-1:0] span_reduce(input logic [COL_W-1:0] col);
    logic [COL_W+2:0] v;
    v = {{3{1'b0}}, col};
    for (int k = 0; k < 8; k++) begin
      if (v >= SPAN_X) begin
        v = v - SPAN_X;
      end
    end
    return v[COL_W-1:0];
  endfunction

  state_t state, state_next;

  logic [AW-1:0]    cursor;
  logic [AW-1:0]    clr_cnt;
  logic [AW-1:0]    dst_addr;
  logic             dst_ok;
  logic [AW-1:0]    src_addr;
  logic             src_ok;
  logic [VAL_W-1:0] wval;
  logic [SUM_W-1:0] acc;
  logic [1:0]       rd_cnt;
  logic             out_valid;
  logic [IDX_W-1:0] out_idx;
  logic [VAL_W-1:0] out_val;
  logic             out_last;

  logic             ram_en;
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [VAL_W-1:0] ram_wdata;
  logic [VAL_W-1:0] ram_rdata;

  logic [COL_W-1:0]    seed_col;
  logic [COL_W-1:0]    src_col;
  logic [AW:0]         dst_x;
  logic [AW:0]         src_x;
  logic [AW-1:0]       rd_addr;
  logic [SUM_W-1:0]    sum_full;
  logic [VAL_W-1:0]    sum_val;
  logic                out_fire;
  logic                in_fire;
  logic [AW+IDX_W-1:0] cur_ext;

  assign seed_col = span_reduce(s_tdata[5:0]);
  assign src_col  = span_reduce(s_tdata[19:14]);
  assign dst_x    = BASE_X + (AW + 1)'(seed_col);
  assign src_x    = BASE_X + (AW + 1)'(src_col);
  assign in_fire  = s_tvalid && s_tready;
  assign sum_full = acc + {{(SUM_W - VAL_W){1'b0}}, ram_rdata};
  assign sum_val  = sum_full[SUM_W-1:2];
  assign out_fire = (state == ST_SUM_WB) && (!out_valid || m_tready);
  assign cur_ext  = {{IDX_W{1'b0}}, cursor};

  always_comb begin
    unique case (rd_cnt)
      2'd0: rd_addr = cursor + W_M1;
      2'd1: rd_addr = cursor + W_0;
      2'd2: rd_addr = cursor + W_P1;
      2'd3: rd_addr = cursor;
    endcase
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = cursor;
    ram_wdata  = wval;
    unique case (state)
      ST_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_cnt;
        ram_wdata = '0;
        if (clr_cnt == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (action_t'(s_tuser))
            ACT_HOT:  state_next = ST_HOT_WR;
            ACT_COOL: state_next = ST_COOL_RD;
            ACT_STEP: state_next = ST_SUM_RD;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_HOT_WR: begin
        ram_en     = dst_ok;
        ram_we     = 1'b1;
        ram_addr   = dst_addr;
        ram_wdata  = wval;
        state_next = ST_IDLE;
      end
      ST_COOL_RD: begin
        ram_en     = src_ok;
        ram_addr   = src_addr;
        state_next = ST_COOL_WR;
      end
      ST_COOL_WR: begin
        ram_en     = dst_ok;
        ram_we     = 1'b1;
        ram_addr   = dst_addr;
        ram_wdata  = src_ok ? {1'b0, ram_rdata[VAL_W-1:1]} : '0;
        state_next = ST_IDLE;
      end
      ST_SUM_RD: begin
        ram_en   = 1'b1;
        ram_addr = rd_addr;
        if (rd_cnt == 2'd3) begin
          state_next = ST_SUM_WB;
        end
      end
      ST_SUM_WB: begin
        if (out_fire) begin
          ram_en     = 1'b1;
          ram_we     = 1'b1;
          ram_addr   = cursor;
          ram_wdata  = sum_val;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      cursor    <= SWEEP_TOP;
      rd_cnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + ONE;
      end
      if (in_fire) begin
        rd_cnt <= '0;
      end else if (state == ST_SUM_RD) begin
        rd_cnt <= rd_cnt + 2'd1;
      end
      if (out_fire) begin
        out_valid <= 1'b1;
        cursor    <= (cursor == ONE) ? SWEEP_TOP : cursor - ONE;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dst_addr <= dst_x[AW-1:0];
      dst_ok   <= dst_x < SIZE_X;
      src_addr <= src_x[AW-1:0];
      src_ok   <= src_x < SIZE_X;
      wval     <= s_tdata[13:6];
    end
    if (state == ST_SUM_RD) begin
      acc <= (rd_cnt == 2'd0) ? '0 : sum_full;
    end
    if (out_fire) begin
      out_idx  <= cur_ext[IDX_W-1:0];
      out_val  <= sum_val;
      out_last <= cursor == ONE;
    end
  end

  feb_ram #(
    .DEPTH(STORE_SIZE),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_val, out_idx};
  assign m_tlast  = out_last;

`ifndef SYNTHESIS
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cursor >= ONE) && (cursor <= SWEEP_TOP))
    else $error("sweep cursor left the averaged region");

  a_write_in_store: assert property (@(posedge clk) disable iff (rst)
    (ram_en && ram_we) |-> ({1'b0, ram_addr} < SIZE_X))
    else $error("store write beyond its depth");

  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_SUM_WB))
    else $error("result appeared without a write-back");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[IDX_W-1:0] == IDX_W'(1)))
    else $error("frame end flagged on a cell other than index one");
`endif

endmodule

[rtl/core/feb_ram.sv]
// Single-port intensity store with a registered read port.
// Depends on feb_pkg for the data width.
module feb_ram import feb_pkg::*; #(
  parameter int DEPTH = DEF_WIDTH * (DEF_HEIGHT + 1),
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [VAL_W-1:0] wdata,
  output logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[dv/tb_fire_effect_buffer_update.sv]
// Self-checking testbench for fire_effect_buffer_update: directed rows, then random seed and step
// transfers under several sender and receiver idling patterns, checked against a local predictor.
// Depends on feb_pkg and the RTL of fire_effect_buffer_update.
module tb_fire_effect_buffer_update;
  import feb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int W        = DEF_WIDTH;
  localparam int H        = DEF_HEIGHT;
  localparam int SPAN     = DEF_SEED_SPAN;
  localparam int CELLS    = W * (H + 1);
  localparam int SEED_ROW = (H - 1) * W;
  localparam int TOP_CELL = SEED_ROW - 1;
  localparam int LIMIT    = 400000;
  localparam int RAND_PER_PHASE = 95;
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    logic             last;
  } cell_upd_t;

  typedef struct packed {
    logic [1:0]       act;
    logic [COL_W-1:0] scol;
    logic [VAL_W-1:0] sval;
    logic [COL_W-1:0] src;
    logic             typed;
    cell_upd_t        upd;
  } dir_row_t;

  localparam int DIR_N = 19;
  localparam dir_row_t DIRECTED [DIR_N] = '{
    '{ACT_STEP, 6'd0,  8'd0,   6'd0,  1'b1, '{12'd3079, 8'd0, 1'b0}},
    '{ACT_HOT,  6'd0,  8'd255, 6'd0,  1'b0, '0},
    '{ACT_HOT,  6'd63, 8'd255, 6'd0,  1'b0, '0},
    '{ACT_HOT,  6'd55, 8'd255, 6'd0,  1'b0, '0},
    '{ACT_HOT,  6'd56, 8'd255, 6'd0,  1'b0, '0},
    '{ACT_HOT,  6'd54, 8'd128, 6'd0,  1'b0, '0},
    '{ACT_COOL, 6'd1,  8'd0,   6'd0,  1'b0, '0},
    '{ACT_COOL, 6'd2,  8'd0,   6'd63, 1'b0, '0},
    '{ACT_COOL, 6'd3,  8'd0,   6'd3,  1'b0, '0},
    '{ACT_STEP, 6'd0,  8'd0,   6'd0,  1'b0, '0},
    '{ACT_NONE, 6'd63, 8'd255, 6'd63, 1'b0, '0},
    '{ACT_STEP, 6'd63, 8'd255, 6'd63, 1'b0, '0},
    '{ACT_HOT,  6'd0,  8'd0,   6'd0,  1'b0, '0},
    '{ACT_COOL, 6'd63, 8'd0,   6'd55, 1'b0, '0},
    '{ACT_STEP, 6'd0,  8'd0,   6'd0,  1'b0, '0},
    '{ACT_HOT,  6'd42, 8'd170, 6'd21, 1'b0, '0},
    '{ACT_HOT,  6'd21, 8'd85,  6'd42, 1'b0, '0},
    '{ACT_STEP, 6'd0,  8'd0,   6'd0,  1'b0, '0},
    '{ACT_STEP, 6'd0,  8'd0,   6'd0,  1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;

  logic [VAL_W-1:0] heat_mem [CELLS];
  int        sweep_pos;
  cell_upd_t upd_q[$];
  int        errs = 0;
  int        cycles = 0;
  int        src_idle_pct = 0;
  int        snk_stall_pct = 0;

  fire_effect_buffer_update u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int heat_at(input int i);
    return (i < CELLS) ? int'(heat_mem[i]) : 0;
  endfunction

  task automatic heat_put(input int i, input int v);
    if (i < CELLS) begin
      heat_mem[i] = v[VAL_W-1:0];
    end
  endtask

  task automatic predict_fire(input logic [1:0] act, input logic [COL_W-1:0] scol,
                              input logic [VAL_W-1:0] sval, input logic [COL_W-1:0] src,
                              output bit made, output cell_upd_t upd);
    int at;
    int from;
    int c;
    int avg;
    at   = SEED_ROW + (int'(scol) % SPAN);
    from = SEED_ROW + (int'(src) % SPAN);
    made = 1'b0;
    upd  = '0;
    case (act)
      ACT_HOT: begin
        heat_put(at, int'(sval));
      end
      ACT_COOL: begin
        heat_put(at, heat_at(from) >> 1);
      end
      ACT_STEP: begin
        c = sweep_pos;
        if (c < 1 || c > TOP_CELL) begin
          c = TOP_CELL;
        end
        avg = (heat_at(c + W - 1) + heat_at(c + W) + heat_at(c + W + 1) + heat_at(c)) >> 2;
        heat_put(c, avg);
        sweep_pos = (c == 1) ? TOP_CELL : c - 1;
        made     = 1'b1;
        upd.idx  = c[IDX_W-1:0];
        upd.val  = avg[VAL_W-1:0];
        upd.last = (c == 1);
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_item(input logic [1:0] act, input logic [COL_W-1:0] scol,
                           input logic [VAL_W-1:0] sval, input logic [COL_W-1:0] src,
                           input bit typed, input cell_upd_t typed_upd);
    bit        made;
    cell_upd_t upd;
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, src, sval, scol};
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
    predict_fire(act, scol, sval, src, made, upd);
    if (made) begin
      upd_q.push_back(typed ? typed_upd : upd);
    end
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
  endtask

  task automatic send_random(input int step_pct, input int hot_pct, input int cool_pct);
    int r;
    logic [1:0] act;
    r = $urandom_range(0, 99);
    if (r < step_pct) begin
      act = ACT_STEP;
    end else if (r < step_pct + hot_pct) begin
      act = ACT_HOT;
    end else if (r < step_pct + hot_pct + cool_pct) begin
      act = ACT_COOL;
    end else begin
      act = ACT_NONE;
    end
    send_item(act, COL_W'($urandom_range(0, 63)), VAL_W'($urandom_range(0, 255)),
              COL_W'($urandom_range(0, 63)), 1'b0, '0);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    cell_upd_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (upd_q.size() == 0) begin
        errs++;
        $display("%0t: result with none expected: idx %0d intensity %0d last %0b",
                 $realtime, m_tdata[11:0], m_tdata[19:12], m_tlast);
      end else begin
        want = upd_q.pop_front();
        if (m_tdata[11:0] !== want.idx) begin
          errs++;
          $display("%0t: cell_index expected %0d actual %0d",
                   $realtime, want.idx, m_tdata[11:0]);
        end
        if (m_tdata[19:12] !== want.val) begin
          errs++;
          $display("%0t: intensity of cell %0d expected %0d actual %0d",
                   $realtime, want.idx, want.val, m_tdata[19:12]);
        end
        if (m_tlast !== want.last) begin
          errs++;
          $display("%0t: frame_done of cell %0d expected %0b actual %0b",
                   $realtime, want.idx, want.last, m_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("** fire_effect_buffer_update: FAILED **");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      heat_mem[i] = '0;
    end
    sweep_pos = TOP_CELL;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int n = 0; n < DIR_N; n++) begin
      send_item(DIRECTED[n].act, DIRECTED[n].scol, DIRECTED[n].sval, DIRECTED[n].src,
                DIRECTED[n].typed, DIRECTED[n].upd);
    end

    // Hold the sender off until the directed results have drained.
    s_tvalid <= 1'b0;
    while (upd_q.size() != 0) @(posedge clk);
    @(posedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 80; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 80; end
        default: begin src_idle_pct = 23; snk_stall_pct = 23; end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        send_random(50, 20, 22);
      end
    end

    s_tvalid <= 1'b0;
    while (upd_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (upd_q.size() != 0) begin
      errs++;
      $display("%0t: %0d results never arrived", $realtime, upd_q.size());
    end
    if (errs == 0) begin
      $display("** fire_effect_buffer_update: PASSED **");
    end else begin
      $display("** fire_effect_buffer_update: FAILED **");
    end
    $finish;
  end

endmodule

[fire_effect_buffer_update.f]
rtl/core/feb_pkg.sv
rtl/core/feb_ram.sv
rtl/core/fire_effect_buffer_update.sv
dv/tb_fire_effect_buffer_update.sv
